@@ hw/rtl/tbrb_pkg.sv @@
// shared types and constants for the two-reader byte ring buffer
`default_nettype none

package tbrb_pkg;

    localparam int TBRB_CAPACITY = 4096;

    localparam int OP_W   = 3;
    localparam int OFF_W  = 13;
    localparam int IDX_W  = 12;
    localparam int LEN_W  = 13;
    localparam int BYTE_W = 8;
    localparam int STAT_W = 2;
    localparam int FREE_W = 13;
    localparam int CNT_W  = 32;

    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 4;
    localparam int M_TDATA_W = 88;
    localparam int M_TUSER_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE     = 3'd0,
        OP_READ      = 3'd1,
        OP_COMMIT_WR = 3'd2,
        OP_COMMIT_RD = 3'd3,
        OP_CLEAR     = 3'd4
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_NODATA  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COMMIT,
        S_CALC,
        S_CHECK,
        S_MOD,
        S_ACCESS,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic commit;
        logic calc;
        logic check;
        logic mod_step;
        logic mem_en;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic data_op;
        logic check_ok;
        logic mod_last;
        logic need_mod;
    } t_stat;

endpackage

`default_nettype wire

@@ hw/rtl/tbrb_ram.sv @@
// generic single-port ram with registered read
`default_nettype none

module tbrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ hw/rtl/tbrb_ctrl.sv @@
// controller state machine of the ring buffer
`default_nettype none

module tbrb_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_s_tvalid,
    output logic                o_s_tready,
    output logic                o_m_tvalid,
    input  wire logic           i_m_tready,
    input  wire tbrb_pkg::t_stat i_stat,
    output tbrb_pkg::t_cmd      o_cmd
);

    import tbrb_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: n_state = S_CALC;
            S_CALC:   n_state = S_CHECK;
            S_CHECK: begin
                if (i_stat.data_op && i_stat.check_ok) begin
                    n_state = i_stat.need_mod ? S_MOD : S_ACCESS;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_MOD: begin
                if (i_stat.mod_last) begin
                    n_state = S_ACCESS;
                end
            end
            S_ACCESS: n_state = S_OUT;
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd       = '0;
        o_s_tready  = 1'b0;
        n_out_valid = r_out_valid && !i_m_tready;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                o_cmd.load = i_s_tvalid;
            end
            S_COMMIT: o_cmd.commit   = 1'b1;
            S_CALC:   o_cmd.calc     = 1'b1;
            S_CHECK:  o_cmd.check    = 1'b1;
            S_MOD:    o_cmd.mod_step = 1'b1;
            S_ACCESS: o_cmd.mem_en   = 1'b1;
            S_OUT: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                end
            end
            default: o_cmd = '0;
        endcase
    end

    assign o_m_tvalid = r_out_valid;

endmodule

`default_nettype wire

@@ hw/rtl/tbrb_dp.sv @@
// datapath: counters, checks, ring position reduction, byte store and result register
`default_nettype none

module tbrb_dp #(
    parameter int CAPACITY = tbrb_pkg::TBRB_CAPACITY
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire tbrb_pkg::t_cmd                  i_cmd,
    output tbrb_pkg::t_stat                      o_stat,
    input  wire logic [tbrb_pkg::S_TDATA_W-1:0]  i_tdata,
    input  wire logic [tbrb_pkg::S_TUSER_W-1:0]  i_tuser,
    output logic      [tbrb_pkg::M_TDATA_W-1:0]  o_tdata,
    output logic      [tbrb_pkg::M_TUSER_W-1:0]  o_tuser
);

    import tbrb_pkg::*;

    localparam int AW        = $clog2(CAPACITY);
    localparam int RW        = 33;
    localparam int MW        = RW + 2;
    localparam int ML_W      = 18;
    localparam int MH_W      = MW - ML_W;
    localparam int PL_W      = RW + ML_W;
    localparam int PH_W      = RW + MH_W;
    localparam int ACC_W     = RW + MW;
    localparam int SH        = RW + AW;
    localparam int MOD_STEPS = 3;
    localparam int KCW       = $clog2(MOD_STEPS);
    localparam bit NEED_MOD  = (CAPACITY & (CAPACITY - 1)) != 0;
    // ceil(2^SH / CAPACITY), exact quotient for any position sum below 2^RW
    localparam logic [63:0] RECIP =
        ((64'd1 << SH) + 64'(CAPACITY) - 64'd1) / 64'(CAPACITY);
    localparam logic [ML_W-1:0]  RCP_LO  = RECIP[ML_W-1:0];
    localparam logic [MH_W-1:0]  RCP_HI  = RECIP[MW-1:ML_W];
    localparam logic [KCW-1:0]   STEP_LO = KCW'(2);
    localparam logic [KCW-1:0]   STEP_HI = KCW'(1);
    localparam logic [CNT_W-1:0] CAP32   = CNT_W'(CAPACITY);

    // latched item
    t_op               r_op;
    logic              r_rd;
    logic [OFF_W-1:0]  r_off;
    logic [IDX_W-1:0]  r_idx;
    logic [LEN_W-1:0]  r_len;
    logic [BYTE_W-1:0] r_din;

    // counters
    logic [CNT_W-1:0] r_wt;
    logic [CNT_W-1:0] r_wrec;
    logic [CNT_W-1:0] r_rt   [2];
    logic [CNT_W-1:0] r_rrec [2];

    // working registers
    logic [CNT_W-1:0] r_b0;
    logic [CNT_W-1:0] r_b1;
    logic [CNT_W-1:0] r_prec;
    logic [RW-1:0]    r_rem;
    logic [PL_W-1:0]  r_pl;
    logic [ACC_W-1:0] r_acc;
    logic [KCW-1:0]   r_cnt;
    logic [FREE_W-1:0] r_free;
    t_status          r_status;

    // result register
    logic [BYTE_W-1:0] r_o_rdata;
    logic [FREE_W-1:0] r_o_free;
    logic [CNT_W-1:0]  r_o_prec;
    logic [CNT_W-1:0]  r_o_total;
    t_status           r_o_status;

    logic [CNT_W-1:0]  big;
    logic [CNT_W-1:0]  free32;
    logic [CNT_W-1:0]  pend;
    logic [CNT_W-1:0]  base;
    logic              wr_ok;
    logic              rd_ok;
    logic [BYTE_W-1:0] ram_q;
    logic [PL_W-1:0]   prod_lo;
    logic [PH_W-1:0]   prod_hi;
    logic [RW-1:0]     quo;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= t_op'(i_tuser[2:0]);
            r_rd  <= i_tuser[3];
            r_off <= i_tdata[12:0];
            r_idx <= i_tdata[24:13];
            r_len <= i_tdata[37:25];
            r_din <= i_tdata[45:38];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wt      <= '0;
            r_wrec    <= '0;
            r_rt[0]   <= '0;
            r_rt[1]   <= '0;
            r_rrec[0] <= '0;
            r_rrec[1] <= '0;
        end else if (i_cmd.commit) begin
            case (r_op)
                OP_COMMIT_WR: begin
                    r_wt   <= r_wt + CNT_W'(r_off);
                    r_wrec <= r_wrec + CNT_W'(1);
                end
                OP_COMMIT_RD: begin
                    r_rt[r_rd]   <= r_rt[r_rd] + CNT_W'(r_off);
                    r_rrec[r_rd] <= r_rrec[r_rd] + CNT_W'(1);
                end
                OP_CLEAR: begin
                    r_wt      <= '0;
                    r_wrec    <= '0;
                    r_rt[0]   <= '0;
                    r_rt[1]   <= '0;
                    r_rrec[0] <= '0;
                    r_rrec[1] <= '0;
                end
                default: r_wt <= r_wt;
            endcase
        end
    end

    assign base = (r_op == OP_WRITE) ? r_wt : r_rt[r_rd];

    // reciprocal products, split in two halves of the constant
    assign prod_lo = PL_W'(r_rem) * PL_W'(RCP_LO);
    assign prod_hi = PH_W'(r_rem) * PH_W'(RCP_HI);
    assign quo     = RW'(r_acc >> SH);

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc) begin
            r_b0   <= r_wt - r_rt[0];
            r_b1   <= r_wt - r_rt[1];
            r_prec <= r_wrec - r_rrec[r_rd];
            r_rem  <= RW'(base) + RW'(r_off) + RW'(r_idx);
            r_cnt  <= KCW'(MOD_STEPS - 1);
        end else if (i_cmd.mod_step) begin
            case (r_cnt)
                STEP_LO: r_pl  <= prod_lo;
                STEP_HI: r_acc <= (ACC_W'(prod_hi) << ML_W) + ACC_W'(r_pl);
                default: r_rem <= r_rem - quo * RW'(CAPACITY);
            endcase
            r_cnt <= r_cnt - KCW'(1);
        end
    end

    always_comb begin
        big    = (r_b0 > r_b1) ? r_b0 : r_b1;
        free32 = (big >= CAP32) ? '0 : CAP32 - big;
        pend   = r_rd ? r_b1 : r_b0;
        wr_ok  = free32 >= CNT_W'(r_len);
        rd_ok  = (pend >= CNT_W'(r_off)) && ((pend - CNT_W'(r_off)) >= CNT_W'(r_len));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.check) begin
            r_free <= free32[FREE_W-1:0];
            if (r_op == OP_WRITE && !wr_ok) begin
                r_status <= ST_NOSPACE;
            end else if (r_op == OP_READ && !rd_ok) begin
                r_status <= ST_NODATA;
            end else begin
                r_status <= ST_OK;
            end
        end
    end

    tbrb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_en    (i_cmd.mem_en),
        .i_we    (r_op == OP_WRITE),
        .i_addr  (r_rem[AW-1:0]),
        .i_wdata (r_din),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_rdata  <= (r_op == OP_READ && r_status == ST_OK) ? ram_q : '0;
            r_o_free   <= r_free;
            r_o_prec   <= r_prec;
            r_o_total  <= r_wt;
            r_o_status <= r_status;
        end
    end

    always_comb begin
        o_stat.data_op  = (r_op == OP_WRITE) || (r_op == OP_READ);
        o_stat.check_ok = (r_op == OP_WRITE) ? wr_ok : rd_ok;
        o_stat.mod_last = (r_cnt == '0);
        o_stat.need_mod = NEED_MOD;
    end

    assign o_tdata = {3'b000, r_o_total, r_o_prec, r_o_free, r_o_rdata};
    assign o_tuser = r_o_status;

endmodule

`default_nettype wire

@@ hw/rtl/two_reader_byte_ring_buffer_top.sv @@
// top level of the two-reader byte ring buffer
//
//  channel   direction  tuser               tdata
//  s_axis    in         operation, reader   offset, index, length, data_in
//  m_axis    out        status              read_data, free_space, pending_records,
//                                           total_written
//
// commits, counter clear, spare operations and refused accesses pass from acceptance
// through S_COMMIT, S_CALC, S_CHECK and S_OUT; an accepted byte access adds S_ACCESS
// for the store port, and a capacity that is not a power of two adds S_MOD, a position
// reduction by reciprocal multiplication
// reset clears all totals and record counts; the byte store keeps its contents
// a result waits in the output register while the next transaction is taken
`default_nettype none

module two_reader_byte_ring_buffer_top #(
    parameter int CAPACITY = tbrb_pkg::TBRB_CAPACITY
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // offset [12:0], index [24:13], length [37:25], data_in [45:38]
    input  wire logic [tbrb_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // operation [2:0], reader [3]
    input  wire logic [tbrb_pkg::S_TUSER_W-1:0]  s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // read_data [7:0], free_space [20:8], pending_records [52:21], total_written [84:53]
    output logic      [tbrb_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // status [1:0]
    output logic      [tbrb_pkg::M_TUSER_W-1:0]  m_axis_tuser
);

    import tbrb_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    tbrb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    tbrb_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .i_tdata (s_axis_tdata),
        .i_tuser (s_axis_tuser),
        .o_tdata (m_axis_tdata),
        .o_tuser (m_axis_tuser)
    );

    a_one_cmd : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.load, cmd.commit, cmd.calc, cmd.check, cmd.mod_step,
                  cmd.mem_en, cmd.out_load}))
        else $error("more than one datapath command");

    a_busy_after_accept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while busy");

    a_no_overwrite : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result register overwritten");

    a_status_code : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser != 2'b11))
        else $error("bad status code");

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
// self-checking bench for the two-reader byte ring buffer: directed table then random transfers
`default_nettype none

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import tbrb_pkg::*;

    localparam int CAP          = TBRB_CAPACITY;
    localparam int RANDOM_ITEMS = 950;
    localparam int STALL_LIMIT  = 2000;
    localparam int DIR_COUNT    = 23;

    localparam logic [OP_W-1:0] OP_SPARE_5 = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic              reader;
        logic [OFF_W-1:0]  offset;
        logic [IDX_W-1:0]  index;
        logic [LEN_W-1:0]  length;
        logic [BYTE_W-1:0] data;
    } ring_item_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [BYTE_W-1:0] rdata;
        logic [FREE_W-1:0] free;
        logic [CNT_W-1:0]  pend;
        logic [CNT_W-1:0]  total;
    } ring_result_t;

    typedef struct packed {
        ring_item_t   item;
        logic         typed;
        ring_result_t res;
    } dir_row_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic [S_TUSER_W-1:0] s_axis_tuser = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [M_TUSER_W-1:0] m_axis_tuser;

    // predictor state
    logic [CNT_W-1:0]  ring_wr_total;
    logic [CNT_W-1:0]  ring_rd_total [2];
    logic [CNT_W-1:0]  ring_wr_recs;
    logic [CNT_W-1:0]  ring_rd_recs [2];
    logic [BYTE_W-1:0] ring_bytes [CAP];
    bit                ring_filled [CAP];
    int                filled_list [$];

    ring_result_t expected_results [$];
    int           err_count = 0;
    int           issued = 0;
    int           stall_cycles = 0;
    bit           calm = 1'b0;

    dir_row_t dir_rows [DIR_COUNT] = '{
        '{'{OP_WRITE,     1'b0, 13'd0,    12'd0,    13'd0,    8'h00}, 1'b1,
          '{ST_OK,      8'h00, 13'd4096, 32'd0, 32'd0}},
        '{'{OP_WRITE,     1'b0, 13'd4096, 12'd4095, 13'd4096, 8'hFF}, 1'b1,
          '{ST_OK,      8'h00, 13'd4096, 32'd0, 32'd0}},
        '{'{OP_WRITE,     1'b1, 13'd0,    12'd1,    13'd4096, 8'hA5}, 1'b1,
          '{ST_OK,      8'h00, 13'd4096, 32'd0, 32'd0}},
        '{'{OP_COMMIT_WR, 1'b0, 13'd4096, 12'd0,    13'd0,    8'h00}, 1'b1,
          '{ST_OK,      8'h00, 13'd0,    32'd1, 32'd4096}},
        '{'{OP_WRITE,     1'b1, 13'd0,    12'd3,    13'd1,    8'h5A}, 1'b1,
          '{ST_NOSPACE, 8'h00, 13'd0,    32'd1, 32'd4096}},
        '{'{OP_WRITE,     1'b0, 13'd0,    12'd2,    13'd0,    8'h3C}, 1'b1,
          '{ST_OK,      8'h00, 13'd0,    32'd1, 32'd4096}},
        '{'{OP_READ,      1'b1, 13'd0,    12'd4095, 13'd4096, 8'h12}, 1'b1,
          '{ST_OK,      8'hFF, 13'd0,    32'd1, 32'd4096}},
        '{'{OP_READ,      1'b0, 13'd4096, 12'd0,    13'd1,    8'h00}, 1'b1,
          '{ST_NODATA,  8'h00, 13'd0,    32'd1, 32'd4096}},
        '{'{OP_READ,      1'b0, 13'd4096, 12'd1,    13'd0,    8'h00}, 1'b1,
          '{ST_OK,      8'hA5, 13'd0,    32'd1, 32'd4096}},
        '{'{OP_COMMIT_RD, 1'b0, 13'd2,    12'd0,    13'd0,    8'h00}, 1'b1,
          '{ST_OK,      8'h00, 13'd0,    32'd0, 32'd4096}},
        '{'{OP_COMMIT_RD, 1'b1, 13'd4096, 12'd0,    13'd0,    8'h00}, 1'b1,
          '{ST_OK,      8'h00, 13'd2,    32'd0, 32'd4096}},
        '{'{OP_COMMIT_RD, 1'b1, 13'd1,    12'd0,    13'd0,    8'h00}, 1'b1,
          '{ST_OK,      8'h00, 13'd0,    32'hFFFF_FFFF, 32'd4096}},
        '{'{OP_READ,      1'b1, 13'd0,    12'd0,    13'd0,    8'h00}, 1'b1,
          '{ST_OK,      8'hA5, 13'd0,    32'hFFFF_FFFF, 32'd4096}},
        '{'{OP_READ,      1'b0, 13'd4095, 12'd0,    13'd0,    8'h00}, 1'b1,
          '{ST_NODATA,  8'h00, 13'd0,    32'd0, 32'd4096}},
        '{'{OP_SPARE_5,   1'b0, 13'd4096, 12'd4095, 13'd4096, 8'hFF}, 1'b1,
          '{ST_OK,      8'h00, 13'd0,    32'd0, 32'd4096}},
        '{'{OP_SPARE_6,   1'b1, 13'd4096, 12'd4095, 13'd4096, 8'hFF}, 1'b1,
          '{ST_OK,      8'h00, 13'd0,    32'hFFFF_FFFF, 32'd4096}},
        '{'{OP_SPARE_7,   1'b0, 13'd4096, 12'd4095, 13'd4096, 8'hFF}, 1'b1,
          '{ST_OK,      8'h00, 13'd0,    32'd0, 32'd4096}},
        '{'{OP_CLEAR,     1'b1, 13'd0,    12'd0,    13'd0,    8'h00}, 1'b1,
          '{ST_OK,      8'h00, 13'd4096, 32'd0, 32'd0}},
        '{'{OP_WRITE,     1'b0, 13'd100,  12'd7,    13'd20,   8'h81}, 1'b1,
          '{ST_OK,      8'h00, 13'd4096, 32'd0, 32'd0}},
        '{'{OP_COMMIT_WR, 1'b0, 13'd110,  12'd0,    13'd0,    8'h00}, 1'b0, '0},
        '{'{OP_READ,      1'b0, 13'd100,  12'd7,    13'd10,   8'h00}, 1'b0, '0},
        '{'{OP_READ,      1'b0, 13'd100,  12'd7,    13'd11,   8'h00}, 1'b1,
          '{ST_NODATA,  8'h00, 13'd3986, 32'd1, 32'd110}},
        '{'{OP_COMMIT_RD, 1'b0, 13'd110,  12'd0,    13'd0,    8'h00}, 1'b0, '0}
    };

    two_reader_byte_ring_buffer_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [CNT_W-1:0] backlog_of(logic r);
        return ring_wr_total - ring_rd_total[r];
    endfunction

    function automatic int free_of();
        logic [CNT_W-1:0] b0;
        logic [CNT_W-1:0] b1;
        logic [CNT_W-1:0] big;
        b0  = backlog_of(1'b0);
        b1  = backlog_of(1'b1);
        big = (b0 > b1) ? b0 : b1;
        if (big >= CAP)
            return 0;
        return CAP - int'(big);
    endfunction

    function automatic logic [IDX_W-1:0] ring_pos(logic [CNT_W-1:0] base, ring_item_t it);
        logic [CNT_W-1:0] sum;
        sum = base + CNT_W'(it.offset) + CNT_W'(it.index);
        return sum[IDX_W-1:0];
    endfunction

    function automatic bit read_allowed(ring_item_t it);
        logic [CNT_W-1:0] pend;
        pend = backlog_of(it.reader);
        return !(pend < it.offset || pend - it.offset < it.length);
    endfunction

    // advances the predictor by one transaction and returns the expected result
    function automatic ring_result_t ring_apply(ring_item_t it);
        ring_result_t res;
        logic [IDX_W-1:0] pos;
        res = '0;
        case (it.op)
            OP_WRITE: begin
                if (free_of() < int'(it.length)) begin
                    res.status = ST_NOSPACE;
                end else begin
                    pos = ring_pos(ring_wr_total, it);
                    ring_bytes[pos] = it.data;
                    if (!ring_filled[pos]) begin
                        ring_filled[pos] = 1'b1;
                        filled_list.push_back(int'(pos));
                    end
                end
            end
            OP_READ: begin
                if (!read_allowed(it))
                    res.status = ST_NODATA;
                else
                    res.rdata = ring_bytes[ring_pos(ring_rd_total[it.reader], it)];
            end
            OP_COMMIT_WR: begin
                ring_wr_total = ring_wr_total + CNT_W'(it.offset);
                ring_wr_recs  = ring_wr_recs + 1;
            end
            OP_COMMIT_RD: begin
                ring_rd_total[it.reader] = ring_rd_total[it.reader] + CNT_W'(it.offset);
                ring_rd_recs[it.reader]  = ring_rd_recs[it.reader] + 1;
            end
            OP_CLEAR: begin
                ring_wr_total    = '0;
                ring_rd_total[0] = '0;
                ring_rd_total[1] = '0;
                ring_wr_recs     = '0;
                ring_rd_recs[0]  = '0;
                ring_rd_recs[1]  = '0;
            end
            default: ;
        endcase
        res.free  = FREE_W'(free_of());
        res.pend  = ring_wr_recs - ring_rd_recs[it.reader];
        res.total = ring_wr_total;
        return res;
    endfunction

    function automatic ring_item_t rand_item();
        ring_item_t it;
        it.op     = OP_W'($urandom_range(0, 3));
        it.reader = 1'($urandom_range(0, 1));
        it.offset = OFF_W'($urandom_range(0, CAP));
        it.index  = IDX_W'($urandom_range(0, CAP - 1));
        it.length = LEN_W'($urandom_range(0, CAP));
        it.data   = BYTE_W'($urandom_range(0, 255));
        return it;
    endfunction

    function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            err_count++;
            $display("%0t: %s mismatch, expected %h actual %h", $realtime, what, want, got);
        end
    endfunction

    // predicts, queues the expectation and drives one transaction
    task automatic issue(ring_item_t it, logic typed, ring_result_t typed_res);
        ring_result_t res;
        int pick;
        while (!calm && $urandom_range(0, 99) < 23) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        // a granted read must land on a byte that has been written
        if (it.op == OP_READ && read_allowed(it)
                && !ring_filled[ring_pos(ring_rd_total[it.reader], it)]) begin
            if (filled_list.size() == 0) begin
                it.op = OP_WRITE;
            end else begin
                pick = filled_list[$urandom_range(0, filled_list.size() - 1)];
                it.index = IDX_W'(CNT_W'(pick) - ring_rd_total[it.reader]
                                  - CNT_W'(it.offset));
            end
        end
        res = ring_apply(it);
        expected_results.push_back(typed ? typed_res : res);
        issued++;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, it.data, it.length, it.index, it.offset};
        s_axis_tuser  <= {it.reader, it.op};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= calm || ($urandom_range(0, 99) >= 23);
    end

    always @(posedge i_clk) begin : collect
        ring_result_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                err_count++;
                $display("%0t: result with nothing expected, expected none actual %h %h",
                         $realtime, m_axis_tuser, m_axis_tdata);
            end else begin
                want = expected_results.pop_front();
                check_field("status", 32'(want.status), 32'(m_axis_tuser[1:0]));
                check_field("read_data", 32'(want.rdata), 32'(m_axis_tdata[7:0]));
                check_field("free_space", 32'(want.free), 32'(m_axis_tdata[20:8]));
                check_field("pending_records", want.pend, m_axis_tdata[52:21]);
                check_field("total_written", want.total, m_axis_tdata[84:53]);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (i_rst_n && stall_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        ring_item_t it;
        int len;
        int n;
        int f;
        int avail;
        int pick;
        logic [CNT_W-1:0] p;
        logic r;

        ring_wr_total = '0;
        ring_rd_total = '{'0, '0};
        ring_wr_recs  = '0;
        ring_rd_recs  = '{'0, '0};
        for (int k = 0; k < CAP; k++) begin
            ring_bytes[k]  = '0;
            ring_filled[k] = 1'b0;
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k])
            issue(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].res);

        while (issued < DIR_COUNT + RANDOM_ITEMS) begin
            calm = (issued >= DIR_COUNT + 300) && (issued < DIR_COUNT + 500);
            pick = $urandom_range(0, 99);
            if ((backlog_of(1'b0) > CAP || backlog_of(1'b1) > CAP) && pick < 25) begin
                it = rand_item();
                it.op = OP_CLEAR;
                issue(it, 1'b0, '0);
            end else if (pick < 40) begin
                // write transfer: bytes then commit when the length fits the free space
                f = free_of();
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, CAP)
                                                  : $urandom_range(1, 16);
                if (len > f && $urandom_range(0, 4) != 0)
                    len = f;
                n = (len == 0) ? 1 : ((len > 12) ? 12 : len);
                for (int k = 0; k < n; k++) begin
                    it = rand_item();
                    it.op     = OP_WRITE;
                    it.offset = '0;
                    it.length = LEN_W'(len);
                    it.index  = (len <= 12) ? IDX_W'(k) : IDX_W'($urandom_range(0, len - 1));
                    issue(it, 1'b0, '0);
                end
                if (len <= f) begin
                    it = rand_item();
                    it.op     = OP_COMMIT_WR;
                    it.offset = OFF_W'(len);
                    issue(it, 1'b0, '0);
                end
            end else if (pick < 75) begin
                // read transfer on one reader: bytes then commit
                r = 1'($urandom_range(0, 1));
                p = backlog_of(r);
                avail = (p > CAP) ? 16 : int'(p);
                len = $urandom_range(0, (avail > 16) ? 16 : avail);
                if (avail > 16 && $urandom_range(0, 7) == 0)
                    len = $urandom_range(0, avail);
                n = (len == 0) ? 1 : ((len > 12) ? 12 : len);
                for (int k = 0; k < n; k++) begin
                    it = rand_item();
                    it.op     = OP_READ;
                    it.reader = r;
                    it.offset = '0;
                    it.length = LEN_W'(len);
                    it.index  = (len <= 12) ? IDX_W'(k) : IDX_W'($urandom_range(0, len - 1));
                    issue(it, 1'b0, '0);
                end
                it = rand_item();
                it.op     = OP_COMMIT_RD;
                it.reader = r;
                it.offset = OFF_W'(len);
                issue(it, 1'b0, '0);
            end else begin
                it = rand_item();
                if ($urandom_range(0, 99) < 4)
                    it.op = OP_CLEAR;
                else if ($urandom_range(0, 99) < 3)
                    it.op = OP_W'($urandom_range(5, 7));
                issue(it, 1'b0, '0);
            end
        end
        s_axis_tvalid <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (err_count == 0 && expected_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ two_reader_byte_ring_buffer_top.f @@
hw/rtl/tbrb_pkg.sv
hw/rtl/tbrb_ram.sv
hw/rtl/tbrb_ctrl.sv
hw/rtl/tbrb_dp.sv
hw/rtl/two_reader_byte_ring_buffer_top.sv
bench/testbench.sv
